/* hdl/stbts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbts_pkg: shared types and constants
// Payload structs, configuration layout and operation codes of the sampler.
// ----------------------------------------------------------------------------
package stbts_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 64;
  localparam int unsigned MAX_HEIGHT_DEF   = 64;
  localparam int unsigned CHANNEL_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned Q_AW         = 2;

  localparam logic signed [31:0] SCALE_RESET    = 32'sd65536;
  localparam logic signed [31:0] SHIFT_RESET    = 32'sd0;
  localparam logic [6:0]         MAP_SIZE_RESET = 7'd64;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  // 3 * 2^16, the constant of the (3 - 2f) factor of the smoothstep cubic
  localparam logic [17:0] SMOOTH_K = 18'd196608;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCALE_X    = 3'd0,
    CFG_SCALE_Y    = 3'd1,
    CFG_SHIFT_X    = 3'd2,
    CFG_SHIFT_Y    = 3'd3,
    CFG_MAP_WIDTH  = 3'd4,
    CFG_MAP_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [11:0]        texel_address;
    logic [15:0]        texel_red;
    logic [15:0]        texel_green;
    logic [15:0]        texel_blue;
  } in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } out_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic [6:0]         map_width;
    logic [6:0]         map_height;
  } cfg_t;

  // rgb packed as {blue, green, red}
  typedef struct packed {
    op_t                op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [11:0]        addr;
    logic [47:0]        rgb;
  } qitem_t;

endpackage
`default_nettype wire

/* hdl/smoothstep_bilinear_texture_sampler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smoothstep_bilinear_texture_sampler: wrapped bilinear RGB texel sampler
// Top level: configuration registers, front queue, transform and fetch.
// ----------------------------------------------------------------------------
// Mode 0 items store one texel and give no result; mode 1 items return one
// blended RGB sample. A sample holds the single texel RAM port for one read
// per neighbour, so the fetch stage takes no new item until all four reads
// of a sample are issued; writes go at one per cycle while the back end is
// not stalled. A four-entry queue behind the input lets items
// be accepted while the back end or the output is stalled. The texel store
// is not cleared: contents are undefined until written. Configuration may
// only be written while the block is idle; cfg_ready is always high.
module smoothstep_bilinear_texture_sampler #(
  parameter int unsigned MAX_WIDTH    = stbts_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT   = stbts_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned CHANNEL_BITS = stbts_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire stbts_pkg::in_t                      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output stbts_pkg::out_t                          out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [stbts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [31:0]                         cfg_data
);

  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  stbts_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x    <= stbts_pkg::SCALE_RESET;
      cfg_r.scale_y    <= stbts_pkg::SCALE_RESET;
      cfg_r.shift_x    <= stbts_pkg::SHIFT_RESET;
      cfg_r.shift_y    <= stbts_pkg::SHIFT_RESET;
      cfg_r.map_width  <= stbts_pkg::MAP_SIZE_RESET;
      cfg_r.map_height <= stbts_pkg::MAP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (stbts_pkg::cfg_idx_t'(cfg_index))
        stbts_pkg::CFG_SCALE_X:    cfg_r.scale_x    <= cfg_data;
        stbts_pkg::CFG_SCALE_Y:    cfg_r.scale_y    <= cfg_data;
        stbts_pkg::CFG_SHIFT_X:    cfg_r.shift_x    <= cfg_data;
        stbts_pkg::CFG_SHIFT_Y:    cfg_r.shift_y    <= cfg_data;
        stbts_pkg::CFG_MAP_WIDTH:  cfg_r.map_width  <= cfg_data[6:0];
        stbts_pkg::CFG_MAP_HEIGHT: cfg_r.map_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic              q_valid, q_ready;
  stbts_pkg::qitem_t q_item;

  stbts_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  logic           x_valid, x_ready;
  stbts_pkg::op_t x_op;
  logic [AW-1:0]  x_idx, x_stride;
  logic [15:0]    x_sx, x_sy;
  logic [11:0]    x_addr;
  logic [47:0]    x_rgb;

  stbts_xform #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .o_valid  (x_valid),
    .o_ready  (x_ready),
    .o_op     (x_op),
    .o_idx    (x_idx),
    .o_stride (x_stride),
    .o_sx     (x_sx),
    .o_sy     (x_sy),
    .o_addr   (x_addr),
    .o_rgb    (x_rgb)
  );

  stbts_fetch #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (x_valid),
    .i_ready   (x_ready),
    .i_op      (x_op),
    .i_idx     (x_idx),
    .i_stride  (x_stride),
    .i_sx      (x_sx),
    .i_sy      (x_sy),
    .i_addr    (x_addr),
    .i_rgb     (x_rgb),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hdl/stbts_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbts_ram: generic single-port RAM
// One access per cycle, read data registered and held when not reading.
// ----------------------------------------------------------------------------
module stbts_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/stbts_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbts_front: input acceptance and classification
// Sorts items into texel writes and samples, drops writes beyond the store
// and queues the rest in order for the back end.
// ----------------------------------------------------------------------------
module stbts_front #(
  parameter int unsigned MAX_WIDTH  = stbts_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = stbts_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire stbts_pkg::in_t    in_data,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output stbts_pkg::qitem_t      q_item
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW1   = (AW > 12 ? AW : 12) + 1;

  stbts_pkg::qitem_t         fifo_r [stbts_pkg::Q_DEPTH];
  logic [stbts_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [stbts_pkg::Q_AW:0]   count_r;

  logic [CW1-1:0]    addr_e;
  logic              keep;
  logic              push, pop;
  stbts_pkg::qitem_t item;

  always_comb begin
    addr_e = CW1'(in_data.texel_address);
    item.op      = (in_data.mode == stbts_pkg::MODE_SAMPLE) ? stbts_pkg::OP_SAMPLE
                                                             : stbts_pkg::OP_WRITE;
    item.coord_x = in_data.coord_x;
    item.coord_y = in_data.coord_y;
    item.addr    = in_data.texel_address;
    item.rgb     = {in_data.texel_blue, in_data.texel_green, in_data.texel_red};
    // writes outside the store are accepted and discarded here
    keep = (item.op == stbts_pkg::OP_SAMPLE) || (addr_e < CW1'(DEPTH));
  end

  assign in_stall = (count_r == (stbts_pkg::Q_AW + 1)'(stbts_pkg::Q_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = fifo_r[rd_ptr_r];
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/stbts_xform.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbts_xform: coordinate transform pipeline
// Scale and shift, floor split, wrap by modulo (eight bits a stage),
// smoothstep weights and texel index. Seven elastic stages.
// ----------------------------------------------------------------------------
module stbts_xform #(
  parameter int unsigned MAX_WIDTH  = stbts_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = stbts_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stbts_pkg::cfg_t   cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire stbts_pkg::qitem_t q_item,
  output logic                   o_valid,
  input  wire logic              o_ready,
  output stbts_pkg::op_t         o_op,
  output logic [AW-1:0]          o_idx,
  output logic [AW-1:0]          o_stride,
  output logic [15:0]            o_sx,
  output logic [15:0]            o_sy,
  output logic [11:0]            o_addr,
  output logic [47:0]            o_rgb
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SW0 = WW > HW ? WW : HW;
  localparam int unsigned SW  = SW0 > 7 ? SW0 : 7;
  localparam int unsigned MX  = MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned RW  = $clog2(MX);

  function automatic logic [RW-1:0] mod8(input logic [RW-1:0] r_in,
                                         input logic [7:0]    bits,
                                         input logic [RW-1:0] p);
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = r_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, p}) t = t - {1'b0, p};
      r = t[RW-1:0];
    end
    return r;
  endfunction

  // clamped map sizes and wrap periods
  logic [SW-1:0] mw_e, mh_e, wc, hc;
  logic [RW-1:0] per_x, per_y;

  always_comb begin
    mw_e = SW'(cfg.map_width);
    mh_e = SW'(cfg.map_height);
    wc = (mw_e < SW'(2)) ? SW'(2) : ((mw_e > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : mw_e);
    hc = (mh_e < SW'(2)) ? SW'(2) : ((mh_e > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : mh_e);
    per_x = RW'(wc - SW'(1));
    per_y = RW'(hc - SW'(1));
  end

  // stage control, carried through all stages
  logic              v_r    [1:7];
  logic              rdy    [1:7];
  stbts_pkg::op_t    op_r   [1:7];
  logic [11:0]       addr_r [1:7];
  logic [47:0]       rgb_r  [1:7];

  always_comb begin
    rdy[7] = !v_r[7] || o_ready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign q_ready = rdy[1];
  assign o_valid = v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 7; k++) v_r[k] <= 1'b0;
    end else begin
      if (rdy[1]) v_r[1] <= q_valid;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op_r[1]   <= q_item.op;
      addr_r[1] <= q_item.addr;
      rgb_r[1]  <= q_item.rgb;
    end
    for (int k = 2; k <= 7; k++) begin
      if (rdy[k]) begin
        op_r[k]   <= op_r[k-1];
        addr_r[k] <= addr_r[k-1];
        rgb_r[k]  <= rgb_r[k-1];
      end
    end
  end

  // datapath registers
  logic signed [63:0] s1_px_r, s1_py_r;
  logic [32:0]        s2_ipx_r, s2_ipy_r;
  logic [15:0]        s2_fx_r, s2_fy_r;
  logic [RW-1:0]      s3_rx_r, s3_ry_r;
  logic [23:0]        s3_ipx_r, s3_ipy_r;
  logic [31:0]        s3_ffx_r, s3_ffy_r;
  logic [15:0]        s3_fx_r, s3_fy_r;
  logic [RW-1:0]      s4_rx_r, s4_ry_r;
  logic [15:0]        s4_ipx_r, s4_ipy_r;
  logic [15:0]        s4_sx_r, s4_sy_r;
  logic [RW-1:0]      s5_rx_r, s5_ry_r;
  logic [7:0]         s5_ipx_r, s5_ipy_r;
  logic [15:0]        s5_sx_r, s5_sy_r;
  logic [RW-1:0]      s6_rx_r, s6_ry_r;
  logic [15:0]        s6_sx_r, s6_sy_r;
  logic [AW-1:0]      s7_idx_r, s7_stride_r;
  logic [15:0]        s7_sx_r, s7_sy_r;

  logic [48:0]   tx, ty;
  logic [49:0]   smx, smy;
  logic [RW-1:0] r0x, r0y;

  always_comb begin
    // floor(coord*scale/2^16) + shift
    tx = {s1_px_r[63], s1_px_r[63:16]} + {{17{cfg.shift_x[31]}}, cfg.shift_x};
    ty = {s1_py_r[63], s1_py_r[63:16]} + {{17{cfg.shift_y[31]}}, cfg.shift_y};
    // sign bit of the integer part weighs -2^32: start the remainder at -1 mod p
    r0x = s2_ipx_r[32] ? per_x - RW'(1) : '0;
    r0y = s2_ipy_r[32] ? per_y - RW'(1) : '0;
    smx = 50'(s3_ffx_r) * 50'(stbts_pkg::SMOOTH_K - {1'b0, s3_fx_r, 1'b0});
    smy = 50'(s3_ffy_r) * 50'(stbts_pkg::SMOOTH_K - {1'b0, s3_fy_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_px_r <= 64'(q_item.coord_x) * 64'(cfg.scale_x);
      s1_py_r <= 64'(q_item.coord_y) * 64'(cfg.scale_y);
    end
    if (rdy[2]) begin
      s2_ipx_r <= tx[48:16];
      s2_ipy_r <= ty[48:16];
      s2_fx_r  <= tx[15:0];
      s2_fy_r  <= ty[15:0];
    end
    if (rdy[3]) begin
      s3_rx_r  <= mod8(r0x, s2_ipx_r[31:24], per_x);
      s3_ry_r  <= mod8(r0y, s2_ipy_r[31:24], per_y);
      s3_ipx_r <= s2_ipx_r[23:0];
      s3_ipy_r <= s2_ipy_r[23:0];
      s3_ffx_r <= 32'(s2_fx_r) * 32'(s2_fx_r);
      s3_ffy_r <= 32'(s2_fy_r) * 32'(s2_fy_r);
      s3_fx_r  <= s2_fx_r;
      s3_fy_r  <= s2_fy_r;
    end
    if (rdy[4]) begin
      s4_rx_r  <= mod8(s3_rx_r, s3_ipx_r[23:16], per_x);
      s4_ry_r  <= mod8(s3_ry_r, s3_ipy_r[23:16], per_y);
      s4_ipx_r <= s3_ipx_r[15:0];
      s4_ipy_r <= s3_ipy_r[15:0];
      s4_sx_r  <= smx[47:32];
      s4_sy_r  <= smy[47:32];
    end
    if (rdy[5]) begin
      s5_rx_r  <= mod8(s4_rx_r, s4_ipx_r[15:8], per_x);
      s5_ry_r  <= mod8(s4_ry_r, s4_ipy_r[15:8], per_y);
      s5_ipx_r <= s4_ipx_r[7:0];
      s5_ipy_r <= s4_ipy_r[7:0];
      s5_sx_r  <= s4_sx_r;
      s5_sy_r  <= s4_sy_r;
    end
    if (rdy[6]) begin
      s6_rx_r <= mod8(s5_rx_r, s5_ipx_r, per_x);
      s6_ry_r <= mod8(s5_ry_r, s5_ipy_r, per_y);
      s6_sx_r <= s5_sx_r;
      s6_sy_r <= s5_sy_r;
    end
    if (rdy[7]) begin
      s7_idx_r    <= AW'(s6_rx_r) + AW'(s6_ry_r) * AW'(wc);
      s7_stride_r <= AW'(wc);
      s7_sx_r     <= s6_sx_r;
      s7_sy_r     <= s6_sy_r;
    end
  end

  assign o_op     = op_r[7];
  assign o_idx    = s7_idx_r;
  assign o_stride = s7_stride_r;
  assign o_sx     = s7_sx_r;
  assign o_sy     = s7_sy_r;
  assign o_addr   = addr_r[7];
  assign o_rgb    = rgb_r[7];

endmodule
`default_nettype wire

/* hdl/stbts_fetch.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbts_fetch: texel store access and bilinear blend
// Writes texels, reads the four neighbours of a sample one after another,
// blends horizontally then vertically and holds the result for transfer.
// ----------------------------------------------------------------------------
module stbts_fetch #(
  parameter int unsigned MAX_WIDTH    = stbts_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT   = stbts_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned CHANNEL_BITS = stbts_pkg::CHANNEL_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           i_valid,
  output logic                i_ready,
  input  wire stbts_pkg::op_t i_op,
  input  wire logic [AW-1:0]  i_idx,
  input  wire logic [AW-1:0]  i_stride,
  input  wire logic [15:0]    i_sx,
  input  wire logic [15:0]    i_sy,
  input  wire logic [11:0]    i_addr,
  input  wire logic [47:0]    i_rgb,
  output logic                out_valid,
  input  wire logic           out_stall,
  output stbts_pkg::out_t     out_data
);

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned TW  = 3 * CB;
  localparam int unsigned HB  = CB + 16;
  localparam int unsigned WAW = AW > 12 ? AW : 12;

  // access stage
  logic           m_v_r;
  stbts_pkg::op_t m_op_r;
  logic [AW-1:0]  m_idx_r, m_stride_r;
  logic [15:0]    m_sx_r, m_sy_r;
  logic [11:0]    m_addr_r;
  logic [47:0]    m_rgb_r;
  logic [1:0]     cnt_r;
  logic [TW-1:0]  t0_r, t1_r;

  // texel latch stage: fourth texel is still on the RAM output
  logic           c0_v_r;
  logic [TW-1:0]  c0_a_r, c0_b_r, c0_c_r;
  logic [15:0]    c0_sx_r, c0_sy_r;

  // horizontal blend stage
  logic           bh_v_r;
  logic [HB-1:0]  bh_h0_r [3];
  logic [HB-1:0]  bh_h1_r [3];
  logic [15:0]    bh_sy_r;

  logic           out_v_r;
  stbts_pkg::out_t out_r;

  logic           rdy_out, rdy_bh, go, act, m_done;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_addr;
  logic [TW-1:0]  ram_wdata, ram_rdata;
  logic [WAW-1:0] waddr_e;

  assign rdy_out = !out_v_r || !out_stall;
  assign rdy_bh  = !bh_v_r || rdy_out;
  // the access stage only moves when the RAM output may change
  assign go      = !c0_v_r || rdy_bh;
  assign act     = m_v_r && go;
  assign m_done  = act && ((m_op_r == stbts_pkg::OP_WRITE) || (cnt_r == 2'd3));
  assign i_ready = !m_v_r || m_done;

  always_comb begin
    logic [CB+15:0] ext;
    waddr_e = WAW'(m_addr_r);
    for (int ch = 0; ch < 3; ch++) begin
      ext = {{CB{1'b0}}, m_rgb_r[ch*16 +: 16]};
      ram_wdata[ch*CB +: CB] = ext[CB-1:0];
    end
    ram_we = act && (m_op_r == stbts_pkg::OP_WRITE);
    ram_re = act && (m_op_r == stbts_pkg::OP_SAMPLE);
    case (cnt_r)
      2'd0:    ram_addr = m_idx_r;
      2'd1:    ram_addr = m_idx_r + AW'(1);
      2'd2:    ram_addr = m_idx_r + m_stride_r;
      default: ram_addr = m_idx_r + m_stride_r + AW'(1);
    endcase
    if (m_op_r == stbts_pkg::OP_WRITE) ram_addr = waddr_e[AW-1:0];
  end

  stbts_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      cnt_r   <= 2'd0;
      c0_v_r  <= 1'b0;
      bh_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (i_ready) begin
        m_v_r <= i_valid;
        cnt_r <= 2'd0;
      end else if (ram_re) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if (go)      c0_v_r  <= m_done && (m_op_r == stbts_pkg::OP_SAMPLE);
      if (rdy_bh)  bh_v_r  <= c0_v_r;
      if (rdy_out) out_v_r <= bh_v_r;
    end
  end

  logic [HB-1:0]  h0_nxt [3];
  logic [HB-1:0]  h1_nxt [3];
  logic [CB-1:0]  v_nxt  [3];
  logic [16:0]    wsx, wsy;

  always_comb begin
    logic [CB+16:0] pa, pb, pc, pd;
    logic [CB+32:0] q0, q1, qs;
    logic [CB+15:0] vp;
    wsx = stbts_pkg::ONE_Q16 - 17'(c0_sx_r);
    wsy = stbts_pkg::ONE_Q16 - 17'(bh_sy_r);
    for (int ch = 0; ch < 3; ch++) begin
      pa = (CB+17)'(c0_a_r[ch*CB +: CB]) * (CB+17)'(wsx);
      pb = (CB+17)'(c0_b_r[ch*CB +: CB]) * (CB+17)'(c0_sx_r);
      pc = (CB+17)'(c0_c_r[ch*CB +: CB]) * (CB+17)'(wsx);
      pd = (CB+17)'(ram_rdata[ch*CB +: CB]) * (CB+17)'(c0_sx_r);
      h0_nxt[ch] = HB'(pa + pb);
      h1_nxt[ch] = HB'(pc + pd);
      q0 = (CB+33)'(bh_h0_r[ch]) * (CB+33)'(wsy);
      q1 = (CB+33)'(bh_h1_r[ch]) * (CB+33)'(bh_sy_r);
      qs = q0 + q1;
      v_nxt[ch] = qs[CB+31:32];
    end
    vp = {16'b0, v_nxt[0]};
    out_r.out_red   = vp[15:0];
    vp = {16'b0, v_nxt[1]};
    out_r.out_green = vp[15:0];
    vp = {16'b0, v_nxt[2]};
    out_r.out_blue  = vp[15:0];
  end

  always_ff @(posedge clk) begin
    if (i_ready) begin
      m_op_r     <= i_op;
      m_idx_r    <= i_idx;
      m_stride_r <= i_stride;
      m_sx_r     <= i_sx;
      m_sy_r     <= i_sy;
      m_addr_r   <= i_addr;
      m_rgb_r    <= i_rgb;
    end
    // RAM output holds the read issued in the previous active cycle
    if (ram_re && cnt_r == 2'd1) t0_r <= ram_rdata;
    if (ram_re && cnt_r == 2'd2) t1_r <= ram_rdata;
    if (go) begin
      c0_a_r  <= t0_r;
      c0_b_r  <= t1_r;
      c0_c_r  <= ram_rdata;
      c0_sx_r <= m_sx_r;
      c0_sy_r <= m_sy_r;
    end
    if (rdy_bh) begin
      bh_h0_r <= h0_nxt;
      bh_h1_r <= h1_nxt;
      bh_sy_r <= c0_sy_r;
    end
    if (rdy_out) begin
      out_data <= out_r;
    end
  end

  assign out_valid = out_v_r;

endmodule
`default_nettype wire

/* dv/sampler_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sampler_checker: scoreboard for the bilinear texel sampler
// Mirrors the registers and the texel map, predicts each sample's blended RGB
// value when its transfer is accepted and compares it with the results.
// ----------------------------------------------------------------------------
module sampler_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire stbts_pkg::in_t                     in_data,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire stbts_pkg::out_t                    out_data,
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready,
  input  wire logic [stbts_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                        cfg_data,
  output int                                      fail_count,
  output int                                      pending
);

  logic signed [31:0] scale_x, scale_y, shift_x, shift_y;
  logic [6:0]         map_w, map_h;
  logic [47:0]        texels [4096];   // {blue, green, red}
  stbts_pkg::out_t    rgb_q[$];

  function automatic int unsigned clamp_size(input logic [6:0] v);
    if (v < 7'd2) return 2;
    if (v > 7'd64) return 64;
    return 32'(v);
  endfunction

  // wrapped integer position and smoothstep weight along one axis
  function automatic void wrap_axis(input logic signed [31:0] c, input logic signed [31:0] sc,
                                    input logic signed [31:0] sh, input int unsigned size,
                                    output int unsigned pos, output longint unsigned wgt);
    longint t, ip, per, m;
    longint unsigned f;
    t = ((longint'(c) * longint'(sc)) >>> 16) + longint'(sh);
    ip = t >>> 16;
    f = t & 64'hFFFF;
    per = longint'(size) - 1;
    m = ip % per;
    if (m < 0) m += per;
    pos = 32'(m);
    wgt = (f * f * (64'd196608 - 2 * f)) >> 32;
  endfunction

  function automatic stbts_pkg::out_t blend_sample(input stbts_pkg::in_t it);
    int unsigned w, h, xi, yi, idx;
    longint unsigned sx, sy, a, b, c, d, h0, h1;
    logic [15:0] ch [3];
    w = clamp_size(map_w);
    h = clamp_size(map_h);
    wrap_axis(it.coord_x, scale_x, shift_x, w, xi, sx);
    wrap_axis(it.coord_y, scale_y, shift_y, h, yi, sy);
    idx = xi + yi * w;
    for (int k = 0; k < 3; k++) begin
      a = 64'(texels[idx][k*16 +: 16]);
      b = 64'(texels[idx + 1][k*16 +: 16]);
      c = 64'(texels[idx + w][k*16 +: 16]);
      d = 64'(texels[idx + w + 1][k*16 +: 16]);
      h0 = a * (65536 - sx) + b * sx;
      h1 = c * (65536 - sx) + d * sx;
      ch[k] = 16'((h0 * (65536 - sy) + h1 * sy) >> 32);
    end
    return '{out_red: ch[0], out_green: ch[1], out_blue: ch[2]};
  endfunction

  always @(posedge clk) begin
    stbts_pkg::out_t exp_rgb;
    if (!rst_n) begin
      scale_x <= stbts_pkg::SCALE_RESET;
      scale_y <= stbts_pkg::SCALE_RESET;
      shift_x <= stbts_pkg::SHIFT_RESET;
      shift_y <= stbts_pkg::SHIFT_RESET;
      map_w   <= stbts_pkg::MAP_SIZE_RESET;
      map_h   <= stbts_pkg::MAP_SIZE_RESET;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (stbts_pkg::cfg_idx_t'(cfg_index))
          stbts_pkg::CFG_SCALE_X:    scale_x <= cfg_data;
          stbts_pkg::CFG_SCALE_Y:    scale_y <= cfg_data;
          stbts_pkg::CFG_SHIFT_X:    shift_x <= cfg_data;
          stbts_pkg::CFG_SHIFT_Y:    shift_y <= cfg_data;
          stbts_pkg::CFG_MAP_WIDTH:  map_w   <= cfg_data[6:0];
          stbts_pkg::CFG_MAP_HEIGHT: map_h   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (rgb_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result transfer: %h", out_data);
        end else begin
          exp_rgb = rgb_q.pop_front();
          if (exp_rgb.out_red !== out_data.out_red || exp_rgb.out_green !== out_data.out_green
              || exp_rgb.out_blue !== out_data.out_blue) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("rgb mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                       exp_rgb.out_red, exp_rgb.out_green, exp_rgb.out_blue,
                       out_data.out_red, out_data.out_green, out_data.out_blue);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode == stbts_pkg::MODE_WRITE)
          texels[in_data.texel_address] <=
            {in_data.texel_blue, in_data.texel_green, in_data.texel_red};
        else
          rgb_q.push_back(blend_sample(in_data));
      end
      pending <= rgb_q.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bilinear texel sampler
// Fills the low part of the texel map, then runs directed and random samples
// and writes over a series of register settings, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  // samples only ever touch texels below this address
  localparam int FILL_DEPTH     = 256;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  stbts_pkg::in_t                     in_data = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  stbts_pkg::out_t                    out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [stbts_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0]                        cfg_data = '0;
  int                                 fail_count, pending;
  bit                                 calm = 1'b1;
  int                                 idle_cycles = 0;

  always #1 clk = ~clk;

  smoothstep_bilinear_texture_sampler u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sampler_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // result side: hold stall for a drawn number of cycles, then take one transfer
  initial begin
    int n;
    forever begin
      n = draw_gap();
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(input stbts_pkg::in_t item);
    repeat (draw_gap()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input stbts_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // let outstanding samples drain and queued writes retire
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] sx, sy, hx, hy, input logic [6:0] w, h);
    settle();
    write_reg(stbts_pkg::CFG_SCALE_X, sx);
    write_reg(stbts_pkg::CFG_SCALE_Y, sy);
    write_reg(stbts_pkg::CFG_SHIFT_X, hx);
    write_reg(stbts_pkg::CFG_SHIFT_Y, hy);
    write_reg(stbts_pkg::CFG_MAP_WIDTH, {25'($urandom), w});
    write_reg(stbts_pkg::CFG_MAP_HEIGHT, {25'($urandom), h});
  endtask

  function automatic stbts_pkg::in_t texel_item(input logic [11:0] addr,
                                                input logic [47:0] rgb);
    stbts_pkg::in_t it;
    it = stbts_pkg::in_t'({$urandom, $urandom, $urandom});
    it.mode = stbts_pkg::MODE_WRITE;
    it.texel_address = addr;
    {it.texel_blue, it.texel_green, it.texel_red} = rgb;
    return it;
  endfunction

  function automatic stbts_pkg::in_t sample_item(input logic [31:0] x, input logic [31:0] y);
    stbts_pkg::in_t it;
    it = stbts_pkg::in_t'({$urandom, $urandom, $urandom});
    it.mode = stbts_pkg::MODE_SAMPLE;
    it.coord_x = x;
    it.coord_y = y;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      2: return {16'($urandom_range(0, 70)), 16'($urandom)};
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [6:0] rand_size();
    return $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(2, 64));
  endfunction

  // map sizes whose used area stays inside the filled texels
  function automatic void rand_dims(output logic [6:0] w, output logic [6:0] h);
    int unsigned wc, hmax;
    w = rand_size();
    wc = (w < 7'd2) ? 2 : ((w > 7'd64) ? 64 : 32'(w));
    hmax = FILL_DEPTH / wc;
    if (hmax > 64) hmax = 64;
    if (wc <= 4 && $urandom_range(0, 3) == 0)
      h = 7'($urandom);
    else
      h = 7'($urandom_range(2, hmax));
  endfunction

  initial begin
    logic [31:0] edge_coord [6];
    logic [31:0] low_coord [3];
    logic [6:0]  pw, ph;
    edge_coord = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
                   32'h0000_FFFF};
    low_coord = '{32'h0000_0000, 32'h0000_8000, 32'h0001_C000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every entry a sample can reach is written before any sample reads it
    for (int a = 0; a < FILL_DEPTH; a++)
      send(texel_item(12'(a), 48'({$urandom, $urandom})));
    send(texel_item(12'd0, 48'h0));
    send(texel_item(12'(FILL_DEPTH - 1), {48{1'b1}}));
    send(texel_item(12'd65, {48{1'b1}}));

    // reset settings: x extremes over the first rows
    calm = 1'b0;
    foreach (edge_coord[i])
      foreach (low_coord[j])
        send(sample_item(edge_coord[i], low_coord[j]));

    // register extremes, including sizes outside the usable range
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 7'd2, 7'd64);
    foreach (edge_coord[i]) send(sample_item(edge_coord[i], edge_coord[5 - i]));
    set_regs(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 7'd0, 7'd127);
    foreach (edge_coord[i]) send(sample_item(edge_coord[i], edge_coord[i]));
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 7'd1, 7'd65);
    foreach (edge_coord[i]) send(sample_item(edge_coord[5 - i], edge_coord[i]));

    for (int phase = 0; phase < 8; phase++) begin
      rand_dims(pw, ph);
      set_regs(rand_scale(), rand_scale(), $urandom, $urandom, pw, ph);
      calm = (phase % 3 == 2);
      repeat (38) begin
        if ($urandom_range(0, 2) == 0)
          send(texel_item(12'($urandom), 48'({$urandom, $urandom})));
        else
          send(sample_item(rand_coord(), rand_coord()));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* smoothstep_bilinear_texture_sampler.f */
hdl/stbts_pkg.sv
hdl/stbts_ram.sv
hdl/stbts_front.sv
hdl/stbts_xform.sv
hdl/stbts_fetch.sv
hdl/smoothstep_bilinear_texture_sampler.sv
dv/sampler_checker.sv
dv/testbench.sv
